// ----- sv/pri_pkg.sv -----
// shared types, constants and state codes for the price radix index
// no dependencies
package pri_pkg;

	localparam int CHUNK_BITS  = 6;
	localparam int TRIE_DEPTH  = 4;
	localparam int NODE_COUNT  = 1024;
	localparam int HANDLE_BITS = 12;

	localparam int FANOUT     = 1 << CHUNK_BITS;
	localparam int NODE_BITS  = $clog2(NODE_COUNT);
	localparam int KEY_BITS   = TRIE_DEPTH * CHUNK_BITS;
	localparam int DEP_BITS   = $clog2(TRIE_DEPTH + 1);
	localparam int WORD_BITS  = FANOUT + 1;
	localparam int PTR_ABITS  = NODE_BITS + CHUNK_BITS;
	localparam int LIMIT_BITS = 24;

	localparam logic [2:0] OP_INSERT  = 3'd0;
	localparam logic [2:0] OP_ERASE   = 3'd1;
	localparam logic [2:0] OP_FIND    = 3'd2;
	localparam logic [2:0] OP_BEST_LO = 3'd3;
	localparam logic [2:0] OP_BEST_HI = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RANGE    = 3'd1;
	localparam logic [2:0] ST_NO_NODES = 3'd2;
	localparam logic [2:0] ST_PRESENT  = 3'd3;
	localparam logic [2:0] ST_ABSENT   = 3'd4;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] price;
		logic [11:0] level_handle;
	} req_t;

	typedef struct packed {
		logic        success;
		logic [2:0]  status;
		logic [11:0] found_handle;
		logic [23:0] found_price;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_CHK, S_POP, S_POPW, S_LEAF,
		S_ERASE, S_PRRD, S_PRW, S_BQ, S_BQW, S_RESP
	} pri_state_t;

endpackage

// ----- sv/pri_bitscan.sv -----
// lowest or highest set bit of a node's child bitmap
// depends on pri_pkg
module pri_bitscan (
	input  logic [pri_pkg::FANOUT-1:0]     bitmap,
	input  logic                           highest,
	output logic [pri_pkg::CHUNK_BITS-1:0] idx
);
	import pri_pkg::*;

	always_comb begin
		idx = '0;
		if (highest) begin
			for (int i = 0; i < FANOUT; i++) begin
				if (bitmap[i]) idx = CHUNK_BITS'(i);
			end
		end else begin
			for (int i = FANOUT - 1; i >= 0; i--) begin
				if (bitmap[i]) idx = CHUNK_BITS'(i);
			end
		end
	end

endmodule

// ----- sv/price_radix_index.sv -----
// price radix index top level: sequencer, node/pointer/handle/stack memories
// depends on pri_pkg and pri_bitscan
//
// channel   dir  handshake             payload
// req       in   req_valid/req_ready   req_t (opcode, price, level_handle)
// rsp       out  rsp_valid/rsp_ready   rsp_t (success, status, found_handle, found_price)
// cfg       in   cfg_valid/cfg_ready   cfg_data (price_limit)
//
// one item at a time; the walk reads, then checks each trie level (S_RD, S_CHK)
// a full find walks every level to the leaf, insert adds a leaf write (S_LEAF) and
// pops each created node in place of its level's read and check (S_POP, S_POPW),
// erase adds S_ERASE, a parent read and a write and read per pruned level, best
// queries step S_RD, S_CHK, S_BQ, S_BQW per level; failed walks end early; a stalled
// result holds the sequencer in its response state; after reset a clearing pass
// zeroes the node memory, req_ready stays low meanwhile; cfg writes are always taken
// a waiting result sits in the output register while the next item is taken
module price_radix_index (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  pri_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output pri_pkg::rsp_t                   rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pri_pkg::LIMIT_BITS-1:0]  cfg_data
);
	import pri_pkg::*;

	// chunk of the key at a given depth, most significant first
	function automatic logic [CHUNK_BITS-1:0] key_chunk(input logic [KEY_BITS-1:0] key,
			input logic [DEP_BITS-1:0] dep);
		int sh;
		sh = (TRIE_DEPTH - 1 - int'(dep)) * CHUNK_BITS;
		if (int'(dep) >= TRIE_DEPTH) return '0;
		return CHUNK_BITS'(key >> sh);
	endfunction

	pri_state_t state_q, state_d;

	// control registers
	logic [LIMIT_BITS-1:0] limit_q;
	logic [NODE_BITS-1:0]  count_q;   // free nodes on the stack
	logic [NODE_BITS-1:0]  low_q;     // lowest count seen: slots below never written
	logic [NODE_BITS-1:0]  clr_q;
	logic                  rsp_valid_q;

	// item and walk registers
	logic [2:0]            op_q;
	logic [KEY_BITS-1:0]   price_q;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic [NODE_BITS-1:0]  node_q;
	logic [DEP_BITS-1:0]   dep_q;
	logic [WORD_BITS-1:0]  word_q;
	logic [NODE_BITS-1:0]  path_q [TRIE_DEPTH+1];
	logic [KEY_BITS-1:0]   acc_q;
	logic [CHUNK_BITS-1:0] bq_c_q;
	logic [2:0]            status_q;
	logic [11:0]           fh_q;
	logic [23:0]           fp_q;
	rsp_t                  rsp_q;

	// memories: node word = {leaf valid, child bitmap}
	logic [WORD_BITS-1:0]   nd_mem [NODE_COUNT];
	logic [NODE_BITS-1:0]   pt_mem [NODE_COUNT*FANOUT];
	logic [HANDLE_BITS-1:0] hd_mem [NODE_COUNT];
	logic [NODE_BITS-1:0]   sk_mem [NODE_COUNT-1];

	logic                   nd_we, pt_we, hd_we, sk_we;
	logic [NODE_BITS-1:0]   nd_wa, nd_ra, hd_wa, hd_ra, sk_wa, sk_ra;
	logic [PTR_ABITS-1:0]   pt_wa, pt_ra;
	logic [WORD_BITS-1:0]   nd_wd, nd_rd;
	logic [NODE_BITS-1:0]   pt_wd, pt_rd, sk_wd, sk_rd;
	logic [HANDLE_BITS-1:0] hd_wd, hd_rd;

	logic [KEY_BITS-1:0]   key;
	logic [CHUNK_BITS-1:0] cur_chunk, par_chunk, scan_idx;
	logic [DEP_BITS-1:0]   missing;
	logic [NODE_BITS-1:0]  pop_slot, pop_node;
	logic [WORD_BITS-1:0]  par_word;
	logic                  at_leaf, walk_op, is_insert, push_ok, rsp_load, accept;

	assign key       = price_q;
	assign cur_chunk = key_chunk(key, dep_q);
	assign par_chunk = key_chunk(key, dep_q - DEP_BITS'(1));
	assign at_leaf   = (dep_q == DEP_BITS'(TRIE_DEPTH));
	assign walk_op   = (op_q == OP_INSERT) || (op_q == OP_ERASE) || (op_q == OP_FIND);
	assign is_insert = (op_q == OP_INSERT);
	assign missing   = DEP_BITS'(TRIE_DEPTH) - dep_q;
	assign pop_slot  = count_q - NODE_BITS'(1);
	// slots at or above the low mark were rewritten by a push since reset
	assign pop_node  = (pop_slot < low_q) ? (NODE_BITS'(NODE_COUNT - 1) - pop_slot) : sk_rd;
	assign par_word  = nd_rd & ~(WORD_BITS'(1) << par_chunk);
	assign push_ok   = (path_q[dep_q] != '0) && (count_q < NODE_BITS'(NODE_COUNT - 1));
	assign accept    = req_valid && req_ready;
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);

	pri_bitscan u_scan (
		.bitmap  (nd_rd[FANOUT-1:0]),
		.highest (op_q == OP_BEST_HI),
		.idx     (scan_idx)
	);

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				if (clr_q == NODE_BITS'(NODE_COUNT - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (req.opcode > OP_BEST_HI) state_d = S_RESP;
					else if (req.opcode <= OP_FIND && req.price > 32'(limit_q)) state_d = S_RESP;
					else state_d = S_RD;
				end
			end
			S_RD: state_d = S_CHK;
			S_CHK: begin
				if (walk_op) begin
					if (at_leaf) begin
						if (is_insert) state_d = nd_rd[FANOUT] ? S_RESP : S_LEAF;
						else if (op_q == OP_ERASE) state_d = nd_rd[FANOUT] ? S_ERASE : S_RESP;
						else state_d = S_RESP;
					end else if (nd_rd[cur_chunk]) begin
						state_d = S_RD;
					end else if (is_insert && count_q >= NODE_BITS'(missing)) begin
						state_d = S_POP;
					end else begin
						state_d = S_RESP;
					end
				end else begin
					if (at_leaf || nd_rd[FANOUT-1:0] == '0) state_d = S_RESP;
					else state_d = S_BQ;
				end
			end
			S_POP:  state_d = S_POPW;
			S_POPW: state_d = (dep_q + DEP_BITS'(1) == DEP_BITS'(TRIE_DEPTH)) ? S_LEAF : S_POP;
			S_LEAF: state_d = S_RESP;
			S_ERASE: state_d = S_PRRD;
			S_PRRD: begin
				if (word_q == '0 && dep_q != '0) state_d = S_PRW;
				else state_d = S_RESP;
			end
			S_PRW: state_d = S_PRRD;
			S_BQ:  state_d = S_BQW;
			S_BQW: state_d = S_RD;
			S_RESP: begin
				if (rsp_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		nd_we = 1'b0; nd_wa = node_q; nd_wd = '0; nd_ra = node_q;
		pt_we = 1'b0; pt_wa = {node_q, cur_chunk}; pt_wd = pop_node;
		pt_ra = {node_q, cur_chunk};
		hd_we = 1'b0; hd_wa = node_q; hd_wd = hdl_q; hd_ra = node_q;
		sk_we = 1'b0; sk_wa = count_q; sk_wd = path_q[dep_q]; sk_ra = pop_slot;
		unique case (state_q)
			S_CLR: begin
				nd_we = 1'b1;
				nd_wa = clr_q;
			end
			S_POPW: begin
				// link the new node under the current one
				pt_we = 1'b1;
				nd_we = 1'b1;
				nd_wd = word_q | (WORD_BITS'(1) << cur_chunk);
			end
			S_LEAF: begin
				nd_we = 1'b1;
				nd_wd = {1'b1, word_q[FANOUT-1:0]};
				hd_we = 1'b1;
			end
			S_ERASE: begin
				nd_we = 1'b1;
				nd_wd = {1'b0, word_q[FANOUT-1:0]};
			end
			S_PRRD: nd_ra = path_q[dep_q - DEP_BITS'(1)];
			S_PRW: begin
				nd_we = 1'b1;
				nd_wa = path_q[dep_q - DEP_BITS'(1)];
				nd_wd = par_word;
				sk_we = push_ok;
			end
			S_BQ: pt_ra = {node_q, bq_c_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nd_we) nd_mem[nd_wa] <= nd_wd;
		nd_rd <= nd_mem[nd_ra];
	end

	always_ff @(posedge clk) begin
		if (pt_we) pt_mem[pt_wa] <= pt_wd;
		pt_rd <= pt_mem[pt_ra];
	end

	always_ff @(posedge clk) begin
		if (hd_we) hd_mem[hd_wa] <= hd_wd;
		hd_rd <= hd_mem[hd_ra];
	end

	always_ff @(posedge clk) begin
		if (sk_we) sk_mem[sk_wa] <= sk_wd;
		sk_rd <= sk_mem[sk_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			limit_q     <= '1;
			count_q     <= NODE_BITS'(NODE_COUNT - 1);
			low_q       <= NODE_BITS'(NODE_COUNT - 1);
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) limit_q <= cfg_data;
			if (state_q == S_CLR) clr_q <= clr_q + NODE_BITS'(1);
			if (state_q == S_POPW) begin
				count_q <= pop_slot;
				if (pop_slot < low_q) low_q <= pop_slot;
			end
			if (state_q == S_PRW && push_ok) count_q <= count_q + NODE_BITS'(1);
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// item payload and walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= req.opcode;
					price_q   <= req.price[KEY_BITS-1:0];
					hdl_q     <= HANDLE_BITS'(req.level_handle);
					node_q    <= '0;
					dep_q     <= '0;
					acc_q     <= '0;
					path_q[0] <= '0;
					fh_q      <= '0;
					fp_q      <= '0;
					status_q  <= (req.opcode <= OP_FIND && req.price > 32'(limit_q)) ?
						ST_RANGE : ST_ABSENT;
				end
			end
			S_CHK: begin
				word_q <= nd_rd;
				if (walk_op) begin
					if (at_leaf) begin
						if (is_insert) status_q <= nd_rd[FANOUT] ? ST_PRESENT : ST_OK;
						else if (nd_rd[FANOUT]) begin
							status_q <= ST_OK;
							if (op_q == OP_FIND) fh_q <= 12'(hd_rd);
						end
					end else if (nd_rd[cur_chunk]) begin
						node_q <= pt_rd;
						path_q[dep_q + DEP_BITS'(1)] <= pt_rd;
						dep_q  <= dep_q + DEP_BITS'(1);
					end else if (is_insert) begin
						status_q <= (count_q < NODE_BITS'(missing)) ? ST_NO_NODES : ST_OK;
					end
				end else if (at_leaf) begin
					if (nd_rd[FANOUT]) begin
						status_q <= ST_OK;
						fp_q     <= 24'(acc_q);
					end
				end else begin
					acc_q  <= (acc_q << CHUNK_BITS) | KEY_BITS'(scan_idx);
					bq_c_q <= scan_idx;
				end
			end
			S_POPW: begin
				// the new node comes off the stack already clear
				node_q <= pop_node;
				word_q <= '0;
				dep_q  <= dep_q + DEP_BITS'(1);
			end
			S_ERASE: begin
				word_q   <= {1'b0, word_q[FANOUT-1:0]};
				status_q <= ST_OK;
			end
			S_PRW: begin
				word_q <= par_word;
				dep_q  <= dep_q - DEP_BITS'(1);
			end
			S_BQW: begin
				node_q <= pt_rd;
				dep_q  <= dep_q + DEP_BITS'(1);
			end
			S_RESP: begin
				if (rsp_load) begin
					rsp_q.success      <= (status_q == ST_OK);
					rsp_q.status       <= status_q;
					rsp_q.found_handle <= fh_q;
					rsp_q.found_price  <= fp_q;
				end
			end
			default: ;
		endcase
	end

endmodule
